// ===== src/smf2_pkg.sv =====
// shared types and constants of the sliding minimum filter
`default_nettype none

package smf2_pkg;

    // sizing constants
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_WINDOW   = 16;
    localparam int PIXEL_BITS   = 32;

    // fixed field widths of the ports
    localparam int DIM_BITS      = 11;
    localparam int WIN_REG_BITS  = 5;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int VALUE_BITS    = 32;
    localparam int LEAD_BITS     = 16;

    // derived widths
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS = $clog2(MAX_WINDOW);
    localparam int HALF_BITS = $clog2(MAX_WINDOW / 2 + 1);
    localparam int SCAN_BITS = (DIM_BITS > COL_BITS + 1) ? DIM_BITS : COL_BITS + 1;
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;

    typedef logic [COL_BITS-1:0]           col_t;
    typedef logic [COL_BITS:0]             wid_t;
    typedef logic [DIM_BITS-1:0]           row_t;
    typedef logic [HALF_BITS-1:0]          half_t;
    typedef logic [SCAN_BITS-1:0]          scan_t;
    typedef logic [LEAD_BITS-1:0]          lead_t;
    typedef logic signed [PIXEL_BITS-1:0]  pix_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_SIZE  = 2'd2
    } cfg_reg_t;

    // item kinds
    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    typedef struct packed {
        func_t                         func;
        logic signed [VALUE_BITS-1:0]  pixel_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  min_value;
        logic                          frame_end;
    } out_item_t;

    // effective geometry after clamping
    typedef struct packed {
        wid_t   width;
        row_t   height;
        half_t  half;
    } cfg_t;

    // control of the shared compare unit
    typedef struct packed {
        logic valid;
        logic first;
    } min_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COL_RD,
        ST_COL_WAIT,
        ST_COL_OUT,
        ST_PIX,
        ST_ROW_SET,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_ROW_WR,
        ST_IN_ADV
    } state_t;

endpackage

`default_nettype wire

// ===== src/smf2_min_unit.sv =====
// shared signed compare unit with running minimum register
`default_nettype none

module smf2_min_unit (
    input  wire logic              aclk,
    input  wire smf2_pkg::min_ctl_t ctl,
    input  wire smf2_pkg::pix_t    din,
    output smf2_pkg::pix_t         acc
);
    import smf2_pkg::*;

    pix_t acc_reg;

    // first sample loads, later samples keep the smaller value
    always_ff @(posedge aclk) begin
        if (ctl.valid) begin
            if (ctl.first || (din < acc_reg)) begin
                acc_reg <= din;
            end
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== src/smf2_seq.sv =====
// sequencer, position counters and line memories of the minimum filter
`default_nettype none

module smf2_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire smf2_pkg::cfg_t       cfg,
    input  wire logic                 cfg_clear,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire smf2_pkg::in_item_t   in_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output smf2_pkg::out_item_t       res_data
);
    import smf2_pkg::*;

    // memories
    pix_t store_mem [STORE_DEPTH];
    pix_t raw_mem   [MAX_WIDTH];

    // control registers
    state_t    state_reg, state_next;
    col_t      in_col_reg, in_col_next;
    row_t      in_row_reg, in_row_next;
    col_t      out_col_reg, out_col_next;
    row_t      out_row_reg, out_row_next;
    lead_t     lead_reg, lead_next;
    min_ctl_t  rd_ctl_reg, rd_ctl_next;
    logic      rd_store_reg, rd_store_next;
    logic      scan_first_reg, scan_first_next;

    // working registers
    func_t     func_reg, func_next;
    pix_t      pixel_reg, pixel_next;
    scan_t     scan_idx_reg, scan_idx_next;
    scan_t     scan_end_reg, scan_end_next;
    col_t      cx_reg, cx_next;
    wid_t      cx_end_reg, cx_end_next;

    // memory ports
    logic                           store_re, store_we;
    logic [SLOT_BITS+COL_BITS-1:0]  store_raddr, store_waddr;
    pix_t                           store_rdata_reg;
    logic                           raw_re, raw_we;
    col_t                           raw_raddr;
    pix_t                           raw_rdata_reg;

    // compare unit
    pix_t      acc;
    pix_t      min_din;

    // derived values
    logic [DIM_BITS:0]   row_sum, h_ext, last_p1, in_row_ext;
    logic [COL_BITS+1:0] half_c, w_c, col_sum, col_lim, cx_c, cx_sum, row_hi, row_lo;
    row_t                half_r, col_lo, in_row_p1, out_row_p1;
    wid_t                half_w, in_col_p1, out_col_p1, cx_p1;
    logic                out_rdy, scan_last, frame_end;

    assign min_din = rd_store_reg ? store_rdata_reg : raw_rdata_reg;

    smf2_min_unit u_min (
        .aclk (aclk),
        .ctl  (rd_ctl_reg),
        .din  (min_din),
        .acc  (acc)
    );

    // readiness of the oldest output pixel and scan bounds
    always_comb begin
        half_r     = row_t'(cfg.half);
        half_w     = wid_t'(cfg.half);
        half_c     = (COL_BITS+2)'(cfg.half);
        w_c        = (COL_BITS+2)'(cfg.width);
        row_sum    = {1'b0, out_row_reg} + (DIM_BITS+1)'(cfg.half);
        h_ext      = {1'b0, cfg.height};
        last_p1    = (row_sum < h_ext) ? row_sum : h_ext;
        in_row_ext = {1'b0, in_row_reg};
        col_sum    = (COL_BITS+2)'(out_col_reg) + half_c;
        col_lim    = (col_sum < w_c) ? col_sum : w_c;
        out_rdy    = (lead_reg != '0) || (in_row_ext >= last_p1) ||
                     (((in_row_ext + 1'b1) == last_p1) &&
                      ((COL_BITS+2)'(in_col_reg) >= col_lim));
        col_lo     = (out_row_reg >= half_r) ? (out_row_reg - half_r) : '0;
        cx_c       = (COL_BITS+2)'(cx_reg);
        cx_sum     = cx_c + half_c;
        row_hi     = (cx_sum < w_c) ? cx_sum : w_c;
        row_lo     = (cx_c >= half_c) ? (cx_c - half_c) : '0;
        in_col_p1  = {1'b0, in_col_reg} + 1'b1;
        out_col_p1 = {1'b0, out_col_reg} + 1'b1;
        cx_p1      = {1'b0, cx_reg} + 1'b1;
        in_row_p1  = in_row_reg + 1'b1;
        out_row_p1 = out_row_reg + 1'b1;
        scan_last  = (scan_idx_reg + 1'b1) >= scan_end_reg;
        frame_end  = (out_col_p1 == cfg.width) && (out_row_p1 == cfg.height);
    end

    // next state and outputs
    always_comb begin
        state_next      = state_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        lead_next       = lead_reg;
        rd_ctl_next     = '0;
        rd_store_next   = rd_store_reg;
        scan_first_next = scan_first_reg;
        func_next       = func_reg;
        pixel_next      = pixel_reg;
        scan_idx_next   = scan_idx_reg;
        scan_end_next   = scan_end_reg;
        cx_next         = cx_reg;
        cx_end_next     = cx_end_reg;

        store_re    = 1'b0;
        store_raddr = {scan_idx_reg[SLOT_BITS-1:0], out_col_reg};
        store_we    = 1'b0;
        store_waddr = {in_row_reg[SLOT_BITS-1:0], cx_reg};
        raw_re      = 1'b0;
        raw_raddr   = scan_idx_reg[COL_BITS-1:0];
        raw_we      = 1'b0;

        in_ready            = 1'b0;
        res_valid           = 1'b0;
        res_data.min_value  = VALUE_BITS'(acc);
        res_data.frame_end  = frame_end;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    func_next  = in_data.func;
                    pixel_next = pix_t'(in_data.pixel_value);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_rdy) begin
                    scan_idx_next   = scan_t'(col_lo);
                    scan_end_next   = scan_t'(last_p1);
                    scan_first_next = 1'b1;
                    state_next      = ST_COL_RD;
                end else if (func_reg == FUNC_PIXEL) begin
                    state_next = ST_PIX;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            // column pass: one stored row minimum per cycle
            ST_COL_RD: begin
                store_re          = 1'b1;
                rd_ctl_next.valid = 1'b1;
                rd_ctl_next.first = scan_first_reg;
                rd_store_next     = 1'b1;
                scan_first_next   = 1'b0;
                scan_idx_next     = scan_idx_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_COL_WAIT;
                end
            end
            ST_COL_WAIT: begin
                state_next = ST_COL_OUT;
            end
            // hand the result over and step the output position
            ST_COL_OUT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (out_col_p1 >= cfg.width) begin
                        out_col_next = '0;
                        if (out_row_p1 >= cfg.height) begin
                            out_row_next = '0;
                            if (lead_reg != '0) begin
                                lead_next = lead_reg - 1'b1;
                            end
                        end else begin
                            out_row_next = out_row_p1;
                        end
                    end else begin
                        out_col_next = col_t'(out_col_p1);
                    end
                    state_next = (func_reg == FUNC_PIXEL) ? ST_PIX : ST_IDLE;
                end
            end
            // store the raw pixel and pick the row minima it completes
            ST_PIX: begin
                raw_we = 1'b1;
                if (in_col_p1 < cfg.width) begin
                    if (in_col_p1 >= half_w) begin
                        cx_next     = col_t'(in_col_p1 - half_w);
                        cx_end_next = in_col_p1 - half_w + 1'b1;
                        state_next  = ST_ROW_SET;
                    end else begin
                        state_next = ST_IN_ADV;
                    end
                end else begin
                    cx_next     = (cfg.width > half_w) ? col_t'(cfg.width - half_w) : '0;
                    cx_end_next = cfg.width;
                    state_next  = ST_ROW_SET;
                end
            end
            ST_ROW_SET: begin
                scan_idx_next   = scan_t'(row_lo);
                scan_end_next   = scan_t'(row_hi);
                scan_first_next = 1'b1;
                state_next      = ST_ROW_RD;
            end
            // row pass: one raw pixel per cycle
            ST_ROW_RD: begin
                raw_re            = 1'b1;
                rd_ctl_next.valid = 1'b1;
                rd_ctl_next.first = scan_first_reg;
                rd_store_next     = 1'b0;
                scan_first_next   = 1'b0;
                scan_idx_next     = scan_idx_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_ROW_WAIT;
                end
            end
            ST_ROW_WAIT: begin
                state_next = ST_ROW_WR;
            end
            ST_ROW_WR: begin
                store_we = 1'b1;
                if (cx_p1 >= cx_end_reg) begin
                    state_next = ST_IN_ADV;
                end else begin
                    cx_next    = cx_reg + 1'b1;
                    state_next = ST_ROW_SET;
                end
            end
            // step the input position
            ST_IN_ADV: begin
                if (in_col_p1 < cfg.width) begin
                    in_col_next = in_col_reg + 1'b1;
                end else begin
                    in_col_next = '0;
                    if (in_row_p1 >= cfg.height) begin
                        in_row_next = '0;
                        if (lead_reg != '1) begin
                            lead_next = lead_reg + 1'b1;
                        end
                    end else begin
                        in_row_next = in_row_p1;
                    end
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (cfg_clear) begin
            state_next   = ST_IDLE;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
            rd_ctl_next  = '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            lead_reg       <= '0;
            rd_ctl_reg     <= '0;
            rd_store_reg   <= 1'b0;
            scan_first_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            lead_reg       <= lead_next;
            rd_ctl_reg     <= rd_ctl_next;
            rd_store_reg   <= rd_store_next;
            scan_first_reg <= scan_first_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        pixel_reg    <= pixel_next;
        scan_idx_reg <= scan_idx_next;
        scan_end_reg <= scan_end_next;
        cx_reg       <= cx_next;
        cx_end_reg   <= cx_end_next;
    end

    // row minimum store
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= acc;
        end
        if (store_re) begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    // raw pixels of the current row
    always_ff @(posedge aclk) begin
        if (raw_we) begin
            raw_mem[in_col_reg] <= pixel_reg;
        end
        if (raw_re) begin
            raw_rdata_reg <= raw_mem[raw_raddr];
        end
    end

`ifndef SYNTH
    ap_out_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        wid_t'(out_col_reg) < cfg.width)
        else $error("output column beyond image width");

    ap_in_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        wid_t'(in_col_reg) < cfg.width)
        else $error("input column beyond image width");

    ap_out_row_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        out_row_reg < cfg.height)
        else $error("output row beyond image height");

    ap_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !rd_ctl_reg.valid)
        else $error("memory read still in flight while idle");

    ap_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_COL_RD) || (state_reg == ST_ROW_RD)) |->
        (scan_idx_reg < scan_end_reg))
        else $error("scan index past its end");
`endif

endmodule

`default_nettype wire

// ===== src/sliding_minimum_filter_2d.sv =====
// top level of the two-dimensional sliding minimum filter
`default_nettype none

// Streaming 2-D minimum filter over a raster-order image. Each pixel item writes
// the raw row buffer; completed row minima (over columns x-half .. x+half-1,
// clipped) go to a 16-row store, and each output pixel is the minimum of that
// store over rows y-half .. y+half-1, clipped. One compare unit does all scans,
// one memory word per cycle. Each item is accepted and then tested for a ready
// output; if it releases a result, a column scan (at most 2*half reads) hands it
// to the output. A pixel is then stored, with a row scan (at most 2*half reads)
// for each row minimum it completes: usually one, and up to half at the end of a
// row. A result waits in an output register, and the next item is accepted
// meanwhile; the block only stalls when a new result is ready and that register
// is still full.
// Drain items release pending results after the last rows. A register write
// restarts the position counters and drops pending results; the memories have
// no reset and need no clearing pass.
module sliding_minimum_filter_2d (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [smf2_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [smf2_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire smf2_pkg::in_item_t                     s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output smf2_pkg::out_item_t                         m_data
);
    import smf2_pkg::*;

    logic [DIM_BITS-1:0]      width_reg;
    logic [DIM_BITS-1:0]      height_reg;
    logic [WIN_REG_BITS-1:0]  window_reg;
    logic                     cfg_hit;
    cfg_t                     cfg;

    logic       res_valid, res_ready;
    out_item_t  res_data;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    // configuration registers
    assign cfg_hit = cfg_we && ((cfg_addr == REG_IMAGE_WIDTH) ||
                                (cfg_addr == REG_IMAGE_HEIGHT) ||
                                (cfg_addr == REG_WINDOW_SIZE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_BITS'(1024);
            height_reg <= DIM_BITS'(1024);
            window_reg <= WIN_REG_BITS'(2);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[DIM_BITS-1:0];
                REG_WINDOW_SIZE:  window_reg <= cfg_wdata[WIN_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp the geometry to what the store holds
    always_comb begin
        if (width_reg == '0) begin
            cfg.width = wid_t'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            cfg.width = wid_t'(MAX_WIDTH);
        end else begin
            cfg.width = wid_t'(width_reg);
        end
        cfg.height = (height_reg == '0) ? row_t'(1) : height_reg;
        if (window_reg < WIN_REG_BITS'(2)) begin
            cfg.half = half_t'(1);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            cfg.half = half_t'(MAX_WINDOW / 2);
        end else begin
            cfg.half = half_t'(window_reg >> 1);
        end
    end

    smf2_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cfg_clear (cfg_hit),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench of the sliding minimum filter: directed table, then random frames
`timescale 1ns / 1ps

module tb;
    import smf2_pkg::*;

    // run limits
    localparam int RANDOM_ITEMS     = 400;
    localparam int PIXEL_CAP        = 60;
    localparam int SETTLE_CYCLES    = 400;
    localparam int SINK_HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DIR_ROWS         = 26;

    // register index that maps to no register
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;
    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_VALUE } row_check_t;
    typedef enum logic [1:0] {
        TRAFFIC_FULL, TRAFFIC_SRC, TRAFFIC_SINK, TRAFFIC_BOTH
    } traffic_mode_t;

    typedef struct packed {
        row_kind_t                 kind;
        row_check_t                check;
        logic [CFG_ADDR_BITS-1:0]  reg_addr;
        logic [CFG_DATA_BITS-1:0]  reg_data;
        in_item_t                  item;
        out_item_t                 result;
    } stim_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    in_item_t                  s_data;
    logic                      m_valid;
    logic                      m_ready;
    out_item_t                 m_data;

    out_item_t      owed_results [$];
    int unsigned    mismatch_count = 0;
    int unsigned    stall_cycles = 0;
    traffic_mode_t  traffic = TRAFFIC_FULL;
    bit             sink_hold_req = 1'b0;
    stim_row_t      dir_tab [DIR_ROWS];

    // filter state mirrored by the predictor
    int unsigned    width_reg, height_reg, window_reg;
    int unsigned    in_x, in_y, out_x, out_y, frames_ahead;
    pix_t           rowmin_mem [STORE_DEPTH];
    pix_t           line_buf [MAX_WIDTH];

    sliding_minimum_filter_2d u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // effective geometry after clamping
    function automatic int unsigned geo_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned geo_height();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function automatic int unsigned geo_half();
        int unsigned s;
        s = window_reg;
        if (s < 2) s = 2;
        if (s > MAX_WINDOW) s = MAX_WINDOW;
        return s / 2;
    endfunction

    // register write: any real register restarts the positions
    function automatic void reg_apply(input logic [CFG_ADDR_BITS-1:0] addr,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (addr)
            REG_IMAGE_WIDTH:  width_reg = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            REG_WINDOW_SIZE:  window_reg = data & 11'h1F;
            default: return;
        endcase
        in_x = 0;
        in_y = 0;
        out_x = 0;
        out_y = 0;
        frames_ahead = 0;
    endfunction

    // oldest output pixel has all its rows and columns in
    function automatic bit result_ready();
        int unsigned w, h, half, last_row, need;
        w = geo_width();
        h = geo_height();
        half = geo_half();
        if (frames_ahead > 0) return 1'b1;
        last_row = ((out_y + half < h) ? out_y + half : h) - 1;
        if (in_y > last_row) return 1'b1;
        if (in_y == last_row) begin
            need = (out_x + half < w) ? out_x + half : w;
            return in_x >= need;
        end
        return 1'b0;
    endfunction

    // column pass over the stored row minima
    function automatic pix_t column_window_min(input int unsigned x, input int unsigned y);
        int unsigned lo, hi, r;
        pix_t m, v;
        lo = (y >= geo_half()) ? y - geo_half() : 0;
        hi = (y + geo_half() < geo_height()) ? y + geo_half() : geo_height();
        m = rowmin_mem[(lo % MAX_WINDOW) * MAX_WIDTH + x];
        for (r = lo + 1; r < hi; r++) begin
            v = rowmin_mem[(r % MAX_WINDOW) * MAX_WIDTH + x];
            if (v < m) m = v;
        end
        return m;
    endfunction

    // row pass for one column of the current line
    function automatic void store_row_min(input int unsigned cx, input int unsigned y);
        int unsigned lo, hi, i;
        pix_t m;
        lo = (cx >= geo_half()) ? cx - geo_half() : 0;
        hi = (cx + geo_half() < geo_width()) ? cx + geo_half() : geo_width();
        m = line_buf[lo];
        for (i = lo + 1; i < hi; i++)
            if (line_buf[i] < m) m = line_buf[i];
        rowmin_mem[(y % MAX_WINDOW) * MAX_WIDTH + cx] = m;
    endfunction

    function automatic void absorb_pixel(input pix_t v);
        int unsigned w, half, ix, cx;
        w = geo_width();
        half = geo_half();
        ix = in_x;
        line_buf[ix] = v;
        if (ix + 1 < w) begin
            if (ix + 1 >= half) store_row_min(ix + 1 - half, in_y);
            in_x = ix + 1;
        end else begin
            for (cx = (w > half) ? w - half : 0; cx < w; cx++)
                store_row_min(cx, in_y);
            in_x = 0;
            in_y++;
            if (in_y >= geo_height()) begin
                in_y = 0;
                if (frames_ahead < 65535) frames_ahead++;
            end
        end
    endfunction

    // one item: release the oldest ready pixel, then take the new one
    function automatic void filter_step(input in_item_t item, output bit has_res,
                                        output out_item_t res);
        int unsigned w, h;
        w = geo_width();
        h = geo_height();
        has_res = 1'b0;
        res = '0;
        if (result_ready()) begin
            has_res = 1'b1;
            res.min_value = column_window_min(out_x, out_y);
            res.frame_end = (out_x + 1 == w) && (out_y + 1 == h);
            out_x++;
            if (out_x >= w) begin
                out_x = 0;
                out_y++;
                if (out_y >= h) begin
                    out_y = 0;
                    if (frames_ahead > 0) frames_ahead--;
                end
            end
        end
        if (item.func == FUNC_PIXEL) absorb_pixel(item.pixel_value);
    endfunction

    function automatic in_item_t make_input(input func_t f, input pix_t v);
        in_item_t it;
        it.func = f;
        it.pixel_value = v;
        return it;
    endfunction

    function automatic stim_row_t mk_item(input func_t f, input logic [31:0] v,
                                          input row_check_t c, input logic [31:0] mv,
                                          input logic fe);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.check = c;
        r.item = make_input(f, v);
        r.result.min_value = mv;
        r.result.frame_end = fe;
        return r;
    endfunction

    function automatic stim_row_t mk_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                                         input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.check = CHK_NONE;
        r.reg_addr = addr;
        r.reg_data = data;
        return r;
    endfunction

    // pixel values biased toward the extremes and toward ties
    function automatic pix_t rand_pixel();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return pix_t'(int'($urandom_range(15)) - 8);
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic bit src_gap();
        case (traffic)
            TRAFFIC_SRC:  return $urandom_range(99) < 45;
            TRAFFIC_BOTH: return $urandom_range(99) < 20;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stall();
        case (traffic)
            TRAFFIC_SINK: return $urandom_range(99) < 45;
            TRAFFIC_BOTH: return $urandom_range(99) < 20;
            default:      return 1'b0;
        endcase
    endfunction

    // offer one item, called just after a falling edge and returning at one
    task automatic send_item(input in_item_t item, input row_check_t check,
                             input out_item_t typed, output bit released);
        bit        has_res;
        out_item_t res;
        while (src_gap()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = item;
        do @(posedge aclk); while (!s_ready);
        filter_step(item, has_res, res);
        case (check)
            CHK_MODEL: if (has_res) owed_results = {owed_results, res};
            CHK_VALUE: owed_results = {owed_results, typed};
            default: ;
        endcase
        released = has_res;
        @(negedge aclk);
    endtask

    // wait for every owed result, then let the last item finish inside the block
    task automatic settle_block();
        s_valid = 1'b0;
        while (owed_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(posedge aclk);
        reg_apply(addr, data);
        @(negedge aclk);
        cfg_we = 1'b0;
        @(negedge aclk);
    endtask

    // result side: random stalls and one long hold-off
    initial begin : sink_side
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_ready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                sink_hold_req = 1'b0;
            end
            m_ready = !sink_stall();
        end
    end

    // compare each accepted result with the oldest owed one
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result min_value %0d frame_end %0b",
                         $time, m_data.min_value, m_data.frame_end);
                mismatch_count++;
            end else begin
                want = owed_results.pop_front();
                if (m_data.min_value !== want.min_value) begin
                    $display("%0t: min_value expected %0d got %0d",
                             $time, want.min_value, m_data.min_value);
                    mismatch_count++;
                end
                if (m_data.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b got %0b",
                             $time, want.frame_end, m_data.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** sliding_minimum_filter_2d: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned               row_idx, phase, frames, total, px, items_done;
        logic [CFG_DATA_BITS-1:0]  w_data, h_data, win_data;
        bit                        got;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;

        // predictor after reset
        width_reg = 1024;
        height_reg = 1024;
        window_reg = 2;
        in_x = 0;
        in_y = 0;
        out_x = 0;
        out_y = 0;
        frames_ahead = 0;

        // defaults (half 1): output (x,0) is the minimum of pixels x-1 and x
        dir_tab = '{
            mk_item(FUNC_PIXEL, 32'h7FFF_FFFF, CHK_NONE,  32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h8000_0000, CHK_VALUE, 32'h7FFF_FFFF, 1'b0),
            mk_item(FUNC_PIXEL, 32'h0000_0005, CHK_VALUE, 32'h8000_0000, 1'b0),
            mk_item(FUNC_PIXEL, 32'hFFFF_FFFF, CHK_VALUE, 32'h8000_0000, 1'b0),
            mk_item(FUNC_DRAIN, 32'hFFFF_FFFF, CHK_VALUE, 32'hFFFF_FFFF, 1'b0),
            // narrow 3x2 image, window 16: every window covers the whole frame
            mk_reg(REG_IMAGE_WIDTH, 11'd3),
            mk_reg(REG_IMAGE_HEIGHT, 11'd2),
            mk_reg(REG_WINDOW_SIZE, 11'd16),
            mk_item(FUNC_PIXEL, 32'h5555_5555, CHK_NONE, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'hAAAA_AAAA, CHK_NONE, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h0000_0000, CHK_NONE, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h7FFF_FFFF, CHK_NONE, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h0000_0001, CHK_NONE, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'hFFFF_FFFE, CHK_NONE, 32'h0, 1'b0),
            // next frame before the drain: old results come first
            mk_item(FUNC_PIXEL, 32'h0000_FFFF, CHK_VALUE, 32'hAAAA_AAAA, 1'b0),
            mk_item(FUNC_PIXEL, 32'hFFFF_0000, CHK_VALUE, 32'hAAAA_AAAA, 1'b0),
            mk_item(FUNC_PIXEL, 32'h1234_5678, CHK_VALUE, 32'hAAAA_AAAA, 1'b0),
            mk_item(FUNC_PIXEL, 32'h8000_0001, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h7FFF_FFFE, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_PIXEL, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h8000_0000, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h7FFF_FFFF, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0),
            mk_item(FUNC_DRAIN, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0)
        };

        // reset
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (row_idx = 0; row_idx < DIR_ROWS; row_idx++) begin
            if (dir_tab[row_idx].kind == ROW_REG) begin
                settle_block();
                cfg_write(dir_tab[row_idx].reg_addr, dir_tab[row_idx].reg_data);
            end else begin
                send_item(dir_tab[row_idx].item, dir_tab[row_idx].check,
                          dir_tab[row_idx].result, got);
            end
        end

        // random phases: mostly whole frames followed by drain items
        phase = 0;
        items_done = 0;
        while (items_done < RANDOM_ITEMS || phase < 10) begin
            w_data = (($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(12, 1)));
            h_data = (($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(6, 1)));
            win_data = 11'($urandom_range(17));
            if ($urandom_range(7) == 0)
                win_data = win_data | 11'($urandom_range(63, 1) << 5);
            case (phase)
                1: begin w_data = 11'd2047; h_data = 11'd1;    win_data = 11'd2;  end
                2: begin w_data = 11'd8;    h_data = 11'd4;    win_data = 11'd4;  end
                3: begin w_data = 11'd1024; h_data = 11'd1;    win_data = 11'd16; end
                4: begin w_data = 11'd6;    h_data = 11'd5;    win_data = 11'd5;  end
                5: begin w_data = 11'd3;    h_data = 11'd2047; win_data = 11'd31; end
                7: begin w_data = 11'd0;    h_data = 11'd0;    win_data = 11'd1;  end
                9: begin w_data = 11'd2;    h_data = 11'd1024; win_data = 11'd4;  end
                default: ;
            endcase
            settle_block();
            cfg_write(REG_IMAGE_WIDTH, w_data);
            cfg_write(REG_IMAGE_HEIGHT, h_data);
            cfg_write(REG_WINDOW_SIZE, win_data);
            traffic = traffic_mode_t'(phase % 4);
            // long hold-off on the result side while items keep coming
            if (phase == 2) sink_hold_req = 1'b1;

            frames = $urandom_range(3, 1);
            total = frames * geo_width() * geo_height();
            if (total > PIXEL_CAP) total = PIXEL_CAP;
            else if ($urandom_range(5) == 0) total = $urandom_range(total, 1);

            for (px = 0; px < total; px++) begin
                // pause until all results are in, then a write to no register
                if (phase == 6 && px == total / 2) begin
                    settle_block();
                    cfg_write(REG_SPARE, 11'($urandom_range(2047)));
                end
                // stray drain item inside a frame
                if ($urandom_range(11) == 0) begin
                    send_item(make_input(FUNC_DRAIN, rand_pixel()), CHK_MODEL, '0, got);
                    if (got) items_done++;
                end
                send_item(make_input(FUNC_PIXEL, rand_pixel()), CHK_MODEL, '0, got);
                items_done++;
            end

            // drain until nothing is ready
            do begin
                send_item(make_input(FUNC_DRAIN, rand_pixel()), CHK_MODEL, '0, got);
                if (got) items_done++;
            end while (got);
            phase++;
        end

        settle_block();
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("** sliding_minimum_filter_2d: PASSED **");
        else
            $display("** sliding_minimum_filter_2d: FAILED **");
        $finish;
    end

endmodule
